### rtl/core/smc_pkg.sv
// smc_pkg: shared types, constants and codes for the STUN message checker.
// Used by every module in rtl/core; depends on nothing.
package smc_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 2048;
    localparam int unsigned HDR_BYTES        = 20;
    localparam int unsigned COUNT_W          = $clog2(MAX_PACKET_BYTES + 1);

    typedef logic [COUNT_W-1:0] t_count;

    localparam t_count COUNT_MAX = t_count'(MAX_PACKET_BYTES);
    localparam t_count COUNT_HDR = t_count'(HDR_BYTES);

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_SHORT     = 3'd1;
    localparam t_status ST_BAD_FIRST = 3'd2;
    localparam t_status ST_LEN_MISM  = 3'd3;
    localparam t_status ST_LEN_ALIGN = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_USE_CAND = 2'd0;
    localparam t_cfg_idx CFG_BIND_REQ = 2'd1;

    localparam logic [15:0] USE_CAND_RST = 16'd37;
    localparam logic [15:0] BIND_REQ_RST = 16'd1;

    // token queue between front and back, result queue after back
    localparam int unsigned TOK_DEPTH = 4;
    localparam int unsigned TOK_PTR_W = $clog2(TOK_DEPTH);
    localparam int unsigned RES_DEPTH = 2;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);

    typedef struct packed {
        logic [7:0] byte_data;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [15:0] message_type;
        logic        is_binding_request;
        logic        use_candidate;
    } t_out;

    typedef enum logic [2:0] {
        CLS_TYPE_HI,
        CLS_TYPE_LO,
        CLS_LEN_HI,
        CLS_LEN_LO,
        CLS_FIXED,
        CLS_BODY
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] data;
        logic       last;
        logic       ovf;
        t_count     count;
    } t_tok;

endpackage

### rtl/core/smc_front.sv
// smc_front: byte counter and byte classifier of the STUN message checker.
// Depends on smc_pkg.
module smc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  smc_pkg::t_in  i_item,
    output logic          o_tok_push,
    output smc_pkg::t_tok o_tok
);

    smc_pkg::t_count r_count;
    smc_pkg::t_count n_count;
    logic            r_ovf;
    logic            n_ovf;
    logic            at_max;
    smc_pkg::t_count cnt_inc;
    logic            ovf_now;
    smc_pkg::t_cls   cls;

    assign at_max  = (r_count == smc_pkg::COUNT_MAX);
    assign cnt_inc = at_max ? r_count : r_count + 1'b1;
    assign ovf_now = r_ovf | at_max;

    always_comb begin
        if (r_count == smc_pkg::t_count'(0)) begin
            cls = smc_pkg::CLS_TYPE_HI;
        end else if (r_count == smc_pkg::t_count'(1)) begin
            cls = smc_pkg::CLS_TYPE_LO;
        end else if (r_count == smc_pkg::t_count'(2)) begin
            cls = smc_pkg::CLS_LEN_HI;
        end else if (r_count == smc_pkg::t_count'(3)) begin
            cls = smc_pkg::CLS_LEN_LO;
        end else if (r_count < smc_pkg::COUNT_HDR) begin
            cls = smc_pkg::CLS_FIXED;
        end else begin
            cls = smc_pkg::CLS_BODY;
        end
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_accept) begin
            if (i_item.last_byte) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else begin
                n_count = cnt_inc;
                n_ovf   = ovf_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    assign o_tok_push  = i_accept;
    assign o_tok.cls   = cls;
    assign o_tok.data  = i_item.byte_data;
    assign o_tok.last  = i_item.last_byte;
    assign o_tok.ovf   = ovf_now;
    assign o_tok.count = cnt_inc;

endmodule

### rtl/core/smc_tok_fifo.sv
// smc_tok_fifo: short token queue between the front and the back.
// Depends on smc_pkg.
module smc_tok_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smc_pkg::t_tok i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output smc_pkg::t_tok o_data
);

    smc_pkg::t_tok                     r_mem [smc_pkg::TOK_DEPTH];
    logic [smc_pkg::TOK_PTR_W-1:0]     r_wptr;
    logic [smc_pkg::TOK_PTR_W-1:0]     r_rptr;
    logic [smc_pkg::TOK_PTR_W:0]       r_level;

    assign o_full  = (r_level == (smc_pkg::TOK_PTR_W + 1)'(smc_pkg::TOK_DEPTH));
    assign o_empty = (r_level == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

### rtl/core/smc_res_fifo.sv
// smc_res_fifo: result queue that decouples the back from the consumer.
// Depends on smc_pkg.
module smc_res_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smc_pkg::t_out i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output smc_pkg::t_out o_data
);

    smc_pkg::t_out                     r_mem [smc_pkg::RES_DEPTH];
    logic [smc_pkg::RES_PTR_W-1:0]     r_wptr;
    logic [smc_pkg::RES_PTR_W-1:0]     r_rptr;
    logic [smc_pkg::RES_PTR_W:0]       r_level;

    assign o_full  = (r_level == (smc_pkg::RES_PTR_W + 1)'(smc_pkg::RES_DEPTH));
    assign o_empty = (r_level == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

### rtl/core/smc_back.sv
// smc_back: header capture, attribute walk and result build of the checker.
// Depends on smc_pkg; fed by smc_tok_fifo, feeds smc_res_fifo.
module smc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tok_empty,
    input  smc_pkg::t_tok i_tok,
    input  logic          i_res_full,
    input  logic [15:0]   i_use_cand_code,
    input  logic [15:0]   i_bind_req_code,
    output logic          o_tok_pop,
    output logic          o_res_push,
    output smc_pkg::t_out o_res
);

    logic [15:0] r_type_word;
    logic [15:0] r_hdr_len;
    logic        r_first_bad;
    logic [23:0] r_shift;
    logic [1:0]  r_idx;
    logic [15:0] r_skip;
    logic        r_walk_done;
    logic        r_seen;

    logic [15:0] n_type_word;
    logic [15:0] n_hdr_len;
    logic        n_first_bad;
    logic [23:0] n_shift;
    logic [1:0]  n_idx;
    logic [15:0] n_skip;
    logic        n_walk_done;
    logic        n_seen;

    logic [15:0] u_type_word;
    logic [15:0] u_hdr_len;
    logic        u_first_bad;
    logic [23:0] u_shift;
    logic [1:0]  u_idx;
    logic [15:0] u_skip;
    logic        u_walk_done;
    logic        u_seen;

    logic        take;
    logic [31:0] attr_hdr;
    logic [16:0] rounded;
    logic        too_short;
    logic [16:0] len_sum;
    smc_pkg::t_status status;

    assign take      = !i_tok_empty && (!i_tok.last || !i_res_full);
    assign o_tok_pop = take;
    assign attr_hdr  = {r_shift, i_tok.data};
    assign rounded   = ({1'b0, attr_hdr[15:0]} + 17'd3) & ~17'd3;

    // per-byte update
    always_comb begin
        u_type_word = r_type_word;
        u_hdr_len   = r_hdr_len;
        u_first_bad = r_first_bad;
        u_shift     = r_shift;
        u_idx       = r_idx;
        u_skip      = r_skip;
        u_walk_done = r_walk_done;
        u_seen      = r_seen;
        unique case (i_tok.cls)
            smc_pkg::CLS_TYPE_HI: begin
                u_type_word = {i_tok.data, 8'h00};
                u_first_bad = (i_tok.data > 8'h01);
            end
            smc_pkg::CLS_TYPE_LO: u_type_word = {r_type_word[15:8], i_tok.data};
            smc_pkg::CLS_LEN_HI:  u_hdr_len   = {i_tok.data, 8'h00};
            smc_pkg::CLS_LEN_LO:  u_hdr_len   = {r_hdr_len[15:8], i_tok.data};
            smc_pkg::CLS_BODY: begin
                if (!r_walk_done) begin
                    if (r_skip != '0) begin
                        u_skip = r_skip - 1'b1;
                    end else begin
                        u_shift = attr_hdr[23:0];
                        if (r_idx != 2'd3) begin
                            u_idx = r_idx + 1'b1;
                        end else begin
                            u_idx = '0;
                            if (attr_hdr[31:16] == i_use_cand_code) begin
                                u_seen = 1'b1;
                            end
                            if (rounded[16]) begin
                                u_walk_done = 1'b1;
                            end else begin
                                u_skip = rounded[15:0];
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_type_word = r_type_word;
        n_hdr_len   = r_hdr_len;
        n_first_bad = r_first_bad;
        n_shift     = r_shift;
        n_idx       = r_idx;
        n_skip      = r_skip;
        n_walk_done = r_walk_done;
        n_seen      = r_seen;
        if (take) begin
            if (i_tok.last) begin
                n_type_word = '0;
                n_hdr_len   = '0;
                n_first_bad = 1'b0;
                n_shift     = '0;
                n_idx       = '0;
                n_skip      = '0;
                n_walk_done = 1'b0;
                n_seen      = 1'b0;
            end else begin
                n_type_word = u_type_word;
                n_hdr_len   = u_hdr_len;
                n_first_bad = u_first_bad;
                n_shift     = u_shift;
                n_idx       = u_idx;
                n_skip      = u_skip;
                n_walk_done = u_walk_done;
                n_seen      = u_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_word <= '0;
            r_hdr_len   <= '0;
            r_first_bad <= 1'b0;
            r_shift     <= '0;
            r_idx       <= '0;
            r_skip      <= '0;
            r_walk_done <= 1'b0;
            r_seen      <= 1'b0;
        end else begin
            r_type_word <= n_type_word;
            r_hdr_len   <= n_hdr_len;
            r_first_bad <= n_first_bad;
            r_shift     <= n_shift;
            r_idx       <= n_idx;
            r_skip      <= n_skip;
            r_walk_done <= n_walk_done;
            r_seen      <= n_seen;
        end
    end

    // result on the last byte
    assign too_short = !i_tok.ovf && (i_tok.count < smc_pkg::COUNT_HDR);
    assign len_sum   = {1'b0, u_hdr_len} + 17'(smc_pkg::HDR_BYTES);

    always_comb begin
        if (too_short) begin
            status = smc_pkg::ST_SHORT;
        end else if (u_first_bad) begin
            status = smc_pkg::ST_BAD_FIRST;
        end else if (i_tok.ovf || (len_sum != 17'(i_tok.count))) begin
            status = smc_pkg::ST_LEN_MISM;
        end else if (u_hdr_len[1:0] != 2'b00) begin
            status = smc_pkg::ST_LEN_ALIGN;
        end else begin
            status = smc_pkg::ST_OK;
        end
    end

    assign o_res_push               = take && i_tok.last;
    assign o_res.status             = status;
    assign o_res.message_type       = too_short ? 16'h0000 : u_type_word;
    assign o_res.is_binding_request = !too_short && (u_type_word == i_bind_req_code);
    assign o_res.use_candidate      = (status == smc_pkg::ST_OK) && u_seen;

endmodule

### rtl/core/stun_message_checker.sv
// STUN message checker: takes a received STUN packet one byte per transfer
// and gives one result per packet. Rate: one byte per clock, sustained;
// full rises only when the four-entry token queue between the byte
// classifier and the header/attribute walker is full, which happens only
// while the two-entry result queue is full and the last byte of a packet
// waits at the walker. The last byte passes through the token queue, and its
// result through the result queue, to the output; it comes later while earlier
// bytes still wait in the token queue. Configuration writes are always ready.
// Depends on smc_pkg, smc_front, smc_tok_fifo, smc_back, smc_res_fifo.
module stun_message_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  smc_pkg::t_in      i_in_item,
    output logic              empty,
    input  logic              pop,
    output smc_pkg::t_out     o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  smc_pkg::t_cfg_idx i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    logic [15:0]   r_use_cand;
    logic [15:0]   r_bind_req;
    logic          in_accept;
    logic          tok_push;
    smc_pkg::t_tok tok_in;
    logic          tok_pop;
    logic          tok_empty;
    smc_pkg::t_tok tok_head;
    logic          res_push;
    logic          res_full;
    smc_pkg::t_out res_in;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_cand <= smc_pkg::USE_CAND_RST;
            r_bind_req <= smc_pkg::BIND_REQ_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                smc_pkg::CFG_USE_CAND: r_use_cand <= i_cfg_data;
                smc_pkg::CFG_BIND_REQ: r_bind_req <= i_cfg_data;
                default: ;
            endcase
        end
    end

    smc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (i_in_item),
        .o_tok_push (tok_push),
        .o_tok      (tok_in)
    );

    smc_tok_fifo u_tok_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (tok_in),
        .i_pop   (tok_pop),
        .o_full  (full),
        .o_empty (tok_empty),
        .o_data  (tok_head)
    );

    smc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tok_empty     (tok_empty),
        .i_tok           (tok_head),
        .i_res_full      (res_full),
        .i_use_cand_code (r_use_cand),
        .i_bind_req_code (r_bind_req),
        .o_tok_pop       (tok_pop),
        .o_res_push      (res_push),
        .o_res           (res_in)
    );

    smc_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop && !empty),
        .o_full  (res_full),
        .o_empty (empty),
        .o_data  (o_out_item)
    );

`ifndef SYNTH
    a_next_after_last_is_type_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_item.last_byte) |=> (!in_accept || tok_in.cls == smc_pkg::CLS_TYPE_HI))
        else $error("byte after packet end not classified as first header byte");

    a_short_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && res_in.status == smc_pkg::ST_SHORT) |->
        (res_in.message_type == 16'h0000 && !res_in.is_binding_request && !res_in.use_candidate))
        else $error("short packet result carries header fields");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> ($past(tok_push) || $past(!tok_empty)))
        else $error("result built without a queued byte");
`endif

endmodule
